[hdl/arcs_pkg.sv]
// Shared types, register indexes and constants for the adaptive read cache sizer.
package arcs_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_UNIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WASTE_FACTOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SIZE = 3'd4;

  // Register values after reset
  localparam logic [30:0] RST_MIN_SIZE     = 31'd4096;
  localparam logic [30:0] RST_MAX_SIZE     = 31'd1048576;
  localparam logic [20:0] RST_SIZE_UNIT    = 21'd4096;
  localparam logic [15:0] RST_WASTE_FACTOR = 16'd100;
  localparam logic [30:0] RST_INITIAL_SIZE = 31'd65536;

  // Percentage scale applied to the bytes read in the waste test
  localparam logic [6:0] WASTE_PCT = 7'd100;

  // Step limits: the step saturates to the 32-bit signed range
  localparam logic signed [31:0] STEP_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] STEP_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] STEP_HALF = 32'sh4000_0000;

  // Configuration registers
  typedef struct packed {
    logic [30:0] min_size;
    logic [30:0] max_size;
    logic [20:0] size_unit;
    logic [15:0] waste_factor;
    logic [30:0] initial_size;
  } cfg_t;

  // Input word
  typedef struct packed {
    logic [31:0] wasted_bytes;
    logic [31:0] bytes_read;
  } item_t;

  // Result word
  typedef struct packed {
    logic [30:0]        cache_size;
    logic signed [31:0] step_now;
    logic               size_changed;
  } result_t;

  // Waste classification of one input word
  typedef struct packed {
    logic low_waste;
    logic nonzero;
  } item_flags_t;

endpackage

[hdl/arcs_update.sv]
// Size and step update for one classified input word.
module arcs_update #(
  parameter int SIZE_BITS = 32
) (
  input  arcs_pkg::cfg_t        cfg,
  input  logic [SIZE_BITS-1:0]  size,
  input  logic signed [31:0]    step,
  input  arcs_pkg::item_flags_t flags,
  output logic [SIZE_BITS-1:0]  size_next,
  output logic signed [31:0]    step_next,
  output arcs_pkg::result_t     result
);

  // Wide enough for the size plus a full step times unit, with a sign bit
  localparam int CALC_W = (SIZE_BITS > 53) ? SIZE_BITS + 1 : 54;

  logic signed [31:0]       g_step;
  logic signed [31:0]       s_step;
  logic signed [31:0]       g_clamp;
  logic signed [31:0]       s_clamp;
  logic signed [32:0]       neg_step;
  logic signed [32:0]       s_inc;
  logic signed [32:0]       s_mag;
  logic signed [32:0]       s_half;
  logic signed [52:0]       g_prod;
  logic signed [52:0]       s_prod;
  logic signed [CALC_W-1:0] cur_ext;
  logic signed [CALC_W-1:0] lo_ext;
  logic signed [CALC_W-1:0] hi_ext;
  logic signed [CALC_W-1:0] g_sum;
  logic signed [CALC_W-1:0] s_sum;
  logic signed [CALC_W-1:0] cur_new;
  logic [SIZE_BITS-1:0]     size_new;

  // Candidate step when growing: double a positive one (saturating), halve and negate a negative one, or start at one
  assign neg_step = -{step[31], step};
  always_comb begin
    if (step > 0) begin
      g_step = (step >= arcs_pkg::STEP_HALF) ? arcs_pkg::STEP_MAX : (step <<< 1);
    end else if (step < 0) begin
      g_step = $signed(32'($unsigned(neg_step) >> 1));
    end else begin
      g_step = 32'sd1;
    end
  end

  // Candidate step when shrinking: the mirror image of growth
  always_comb begin
    if (step < 0) begin
      s_step = (step < -arcs_pkg::STEP_HALF) ? arcs_pkg::STEP_MIN : (step <<< 1);
    end else if (step > 0) begin
      s_step = -(step >>> 1);
    end else begin
      s_step = -32'sd1;
    end
  end

  // Step after hitting a bound: moved one toward zero, then halved with truncation toward zero
  assign g_clamp = (g_step == 32'sd0) ? 32'sd0 : ((g_step - 32'sd1) >>> 1);
  assign s_inc   = {s_step[31], s_step} + 33'sd1;
  assign s_mag   = (s_inc < 0) ? -s_inc : s_inc;
  assign s_half  = s_mag >>> 1;
  assign s_clamp = 32'((s_inc < 0) ? -s_half : s_half);

  // Both moves are formed side by side; the waste class picks one
  assign g_prod  = g_step * $signed({1'b0, cfg.size_unit});
  assign s_prod  = s_step * $signed({1'b0, cfg.size_unit});
  assign cur_ext = $signed({{(CALC_W-SIZE_BITS){1'b0}}, size});
  assign lo_ext  = $signed(CALC_W'(cfg.min_size));
  assign hi_ext  = $signed(CALC_W'(cfg.max_size));
  assign g_sum   = cur_ext + CALC_W'(g_prod);
  assign s_sum   = cur_ext + CALC_W'(s_prod);

  // Select the move and clamp onto the bound it crosses
  always_comb begin
    cur_new   = cur_ext;
    step_next = step;
    if (flags.low_waste) begin
      if (cur_ext < hi_ext) begin
        if (g_sum > hi_ext) begin
          cur_new   = hi_ext;
          step_next = g_clamp;
        end else begin
          cur_new   = g_sum;
          step_next = g_step;
        end
      end
    end else if (flags.nonzero) begin
      if (cur_ext > lo_ext) begin
        if (s_sum < lo_ext) begin
          cur_new   = lo_ext;
          step_next = s_clamp;
        end else begin
          cur_new   = s_sum;
          step_next = s_step;
        end
      end
    end
  end

  // The size never goes negative and is kept to SIZE_BITS
  assign size_new  = (cur_new < 0) ? '0 : SIZE_BITS'(cur_new);
  assign size_next = size_new;

  // Result word
  assign result.cache_size   = 31'(size_new);
  assign result.step_now     = step_next;
  assign result.size_changed = (size_new != size);

endmodule

[hdl/adaptive_read_cache_sizer.sv]
// Adaptive read cache sizer: configuration, input and result registers around the update.
// A word passes from the input register to the result register; a held-up result stalls it.
// Throughput: one word per cycle while no result is held up; the size and step
// registers are fed back through the step update, a 32 x 22 signed multiply,
// an add and a bound compare. The input register, if empty, takes a word while a finished result waits to be taken.
// Reset (rst, synchronous) loads the register defaults, sets the size to the
// initial size and the step to zero, and empties both stages.
module adaptive_read_cache_sizer #(
  parameter int SIZE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  arcs_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output arcs_pkg::result_t                result,
  input  logic                             cfg_we,
  input  logic [arcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  arcs_pkg::cfg_t        cfg;
  logic [SIZE_BITS-1:0]  size;
  logic signed [31:0]    step;
  logic                  item_full;
  arcs_pkg::item_flags_t item_flags;
  arcs_pkg::item_flags_t flags_next;
  logic [SIZE_BITS-1:0]  size_next;
  logic signed [31:0]    step_next;
  arcs_pkg::result_t     result_next;
  logic [47:0]           waste_scaled;
  logic [38:0]           read_scaled;
  logic                  item_take;
  logic                  advance;

  // Handshake: the input stage moves on unless a result is held up
  assign advance    = item_full && !(result_valid && result_stall);
  assign item_stall = item_full && result_valid && result_stall;
  assign item_take  = item_valid && !item_stall;

  // Waste test on the incoming word
  assign waste_scaled         = cfg.waste_factor * item.wasted_bytes;
  assign read_scaled          = arcs_pkg::WASTE_PCT * item.bytes_read;
  assign flags_next.low_waste = waste_scaled < 48'(read_scaled);
  assign flags_next.nonzero   = item.wasted_bytes != 32'd0;

  arcs_update #(
    .SIZE_BITS (SIZE_BITS)
  ) u_update (
    .cfg       (cfg),
    .size      (size),
    .step      (step),
    .flags     (item_flags),
    .size_next (size_next),
    .step_next (step_next),
    .result    (result_next)
  );

  // Configuration registers and tuning state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_size     <= arcs_pkg::RST_MIN_SIZE;
      cfg.max_size     <= arcs_pkg::RST_MAX_SIZE;
      cfg.size_unit    <= arcs_pkg::RST_SIZE_UNIT;
      cfg.waste_factor <= arcs_pkg::RST_WASTE_FACTOR;
      cfg.initial_size <= arcs_pkg::RST_INITIAL_SIZE;
      size             <= SIZE_BITS'(arcs_pkg::RST_INITIAL_SIZE);
      step             <= 32'sd0;
    end else begin
      // Writing the initial size reloads the size at once; the step is kept.
      if (cfg_we && cfg_index == arcs_pkg::REG_INITIAL_SIZE) begin
        size <= SIZE_BITS'(cfg_data);
      end else if (advance) begin
        size <= size_next;
      end
      if (advance) begin
        step <= step_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          arcs_pkg::REG_MIN_SIZE:     cfg.min_size     <= cfg_data;
          arcs_pkg::REG_MAX_SIZE:     cfg.max_size     <= cfg_data;
          arcs_pkg::REG_SIZE_UNIT:    cfg.size_unit    <= cfg_data[20:0];
          arcs_pkg::REG_WASTE_FACTOR: cfg.waste_factor <= cfg_data[15:0];
          arcs_pkg::REG_INITIAL_SIZE: cfg.initial_size <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_take) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      item_flags <= flags_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

[hdl/arcs_checker.sv]
// Port-level checks for the adaptive read cache sizer, bound to the top level.
module arcs_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input arcs_pkg::result_t result
);

  // A held-up result word stays put
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // The input side only stalls when a result is held up
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with the result side free");

  // A fresh result follows a word accepted into the input register
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
    else $error("result appeared without an accepted word");

  // An accepted word reaches the result register when the output is free
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst, 2) && !$past(rst, 1) && $past(item_valid && !item_stall, 2)
      && !$past(result_valid && result_stall, 1) |-> result_valid)
    else $error("accepted word did not produce a result");

endmodule

bind adaptive_read_cache_sizer arcs_checker u_arcs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

[dv/adaptive_read_cache_sizer_checker.sv]
// Checker for the adaptive read cache sizer: predicts every tuning result and compares it.
`timescale 1ns / 1ps

module adaptive_read_cache_sizer_checker
  import arcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    mismatches
);

  // Shadow registers and tuning state, kept in step with the block.
  cfg_t            shadow_cfg;
  longint unsigned size_now;
  longint          step_cnt;
  result_t         expected_tunings[$];

  // Clamp a step to the 32-bit signed range.
  function automatic longint saturate_step(input longint v);
    if (v > longint'(STEP_MAX)) return longint'(STEP_MAX);
    if (v < longint'(STEP_MIN)) return longint'(STEP_MIN);
    return v;
  endfunction

  // Apply one word to the shadow state and return the result it should produce.
  function automatic result_t tune_size(input item_t w);
    longint unsigned waste_side;
    longint unsigned read_side;
    longint unsigned prior;
    longint          cur;
    longint          stp;
    longint          unit;
    longint          lo;
    longint          hi;
    result_t         r;
    prior      = size_now;
    cur        = size_now;
    stp        = step_cnt;
    unit       = shadow_cfg.size_unit;
    lo         = shadow_cfg.min_size;
    hi         = shadow_cfg.max_size;
    waste_side = shadow_cfg.waste_factor;
    waste_side = waste_side * w.wasted_bytes;
    read_side  = WASTE_PCT;
    read_side  = read_side * w.bytes_read;
    if (waste_side < read_side) begin
      // Little waste: grow towards the upper bound.
      if (cur < hi) begin
        if (stp > 0) stp = saturate_step(stp * 2);
        else if (stp < 0) stp = stp / -2;
        else stp = 1;
        cur += stp * unit;
        if (cur > hi) begin
          cur = hi;
          stp = (stp - 1) / 2;
        end
      end
    end else if (w.wasted_bytes != 0) begin
      // Real waste: shrink towards the lower bound.
      if (cur > lo) begin
        if (stp < 0) stp = saturate_step(stp * 2);
        else if (stp > 0) stp = stp / -2;
        else stp = -1;
        cur += stp * unit;
        if (cur < lo) begin
          cur = lo;
          stp = (stp + 1) / 2;
        end
      end
    end
    if (cur < 0) cur = 0;
    size_now       = cur[31:0];
    step_cnt       = saturate_step(stp);
    r.cache_size   = size_now[30:0];
    r.step_now     = step_cnt[31:0];
    r.size_changed = (size_now != prior);
    return r;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Watch the configuration port and both channels at every rising edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shadow_cfg.min_size     = RST_MIN_SIZE;
      shadow_cfg.max_size     = RST_MAX_SIZE;
      shadow_cfg.size_unit    = RST_SIZE_UNIT;
      shadow_cfg.waste_factor = RST_WASTE_FACTOR;
      shadow_cfg.initial_size = RST_INITIAL_SIZE;
      size_now                = RST_INITIAL_SIZE;
      step_cnt                = 0;
      expected_tunings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_SIZE:     shadow_cfg.min_size = cfg_data;
          REG_MAX_SIZE:     shadow_cfg.max_size = cfg_data;
          REG_SIZE_UNIT:    shadow_cfg.size_unit = cfg_data[20:0];
          REG_WASTE_FACTOR: shadow_cfg.waste_factor = cfg_data[15:0];
          REG_INITIAL_SIZE: begin
            // Writing the initial size reloads the size; the step is kept.
            shadow_cfg.initial_size = cfg_data;
            size_now = cfg_data;
          end
          default: ;
        endcase
      end
      if (item_valid && !item_stall) expected_tunings.push_back(tune_size(item));
      if (result_valid && !result_stall) begin
        if (expected_tunings.size() == 0) begin
          report_mismatch("result word with nothing expected", result.cache_size, -1);
        end else begin
          want = expected_tunings.pop_front();
          if (result.cache_size !== want.cache_size)
            report_mismatch("cache_size", result.cache_size, want.cache_size);
          if (result.step_now !== want.step_now)
            report_mismatch("step_now", $signed(result.step_now), $signed(want.step_now));
          if (result.size_changed !== want.size_changed)
            report_mismatch("size_changed", result.size_changed, want.size_changed);
        end
      end
    end
    pending = expected_tunings.size();
  end

endmodule

[dv/adaptive_read_cache_sizer_tb.sv]
// Testbench top for the adaptive read cache sizer: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module adaptive_read_cache_sizer_tb;
  import arcs_pkg::*;

  localparam int HOLD_CYCLES = 60;

  typedef enum {RUN_GROW, RUN_SHRINK, RUN_NOISE} run_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    pending;
  int                    mismatches;
  bit                    calm = 1'b0;
  bit                    hold_off_req = 1'b0;
  logic [15:0]           factor_now = RST_WASTE_FACTOR;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adaptive_read_cache_sizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  adaptive_read_cache_sizer_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .mismatches   (mismatches)
  );

  // Hard limit on the run.
  initial begin
    #5ms;
    $display("adaptive_read_cache_sizer regression: fail");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        result_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        result_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 18);
        result_stall = 1'b1;
        repeat (burst) @(negedge clk);
        result_stall = 1'b0;
      end
    end
  end

  // Offer one word, sometimes after a gap, and wait until it is taken.
  task automatic send_word(input item_t w);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    item = w;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Wait until every expected result has come back and the pipeline is empty.
  task automatic drain();
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == REG_WASTE_FACTOR) factor_now = data[15:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [30:0] lo, input logic [30:0] hi,
                           input logic [30:0] unit, input logic [30:0] factor,
                           input logic [30:0] start);
    drain();
    write_reg(REG_MIN_SIZE, lo);
    write_reg(REG_MAX_SIZE, hi);
    write_reg(REG_SIZE_UNIT, unit);
    write_reg(REG_WASTE_FACTOR, factor);
    write_reg(REG_INITIAL_SIZE, start);
  endtask

  // A word whose waste counts as small under the current factor.
  function automatic item_t small_waste_word();
    item_t           w;
    longint unsigned room;
    longint unsigned f;
    w.bytes_read = $urandom >> $urandom_range(0, 31);
    if (w.bytes_read == 0) w.bytes_read = 1;
    f = (factor_now == 0) ? 1 : factor_now;
    room = (longint'(WASTE_PCT) * w.bytes_read - 1) / f;
    if (room > 64'hFFFF_FFFF) room = 64'hFFFF_FFFF;
    w.wasted_bytes = {$urandom, $urandom} % (room + 1);
    return w;
  endfunction

  // A word with nonzero waste that does not count as small.
  function automatic item_t large_waste_word();
    item_t           w;
    longint unsigned room;
    w.wasted_bytes = $urandom >> $urandom_range(0, 31);
    if (w.wasted_bytes == 0) w.wasted_bytes = 1;
    room = (longint'(factor_now) * w.wasted_bytes) / WASTE_PCT;
    if (room > 64'hFFFF_FFFF) room = 64'hFFFF_FFFF;
    w.bytes_read = {$urandom, $urandom} % (room + 1);
    return w;
  endfunction

  // Runs of growing or shrinking words with random content, and some noise.
  task automatic random_block(input int count, input int min_run, input int max_run);
    int        left;
    int        run;
    run_kind_t kind;
    item_t     w;
    left = count;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: kind = RUN_GROW;
        4, 5, 6, 7: kind = RUN_SHRINK;
        default:    kind = RUN_NOISE;
      endcase
      run = $urandom_range(min_run, max_run);
      if (run > left) run = left;
      repeat (run) begin
        case (kind)
          RUN_GROW:   w = small_waste_word();
          RUN_SHRINK: w = large_waste_word();
          default: begin
            w = {$urandom, $urandom};
            if ($urandom_range(0, 7) == 0) w = '0;
          end
        endcase
        send_word(w);
      end
      left -= run;
    end
  endtask

  initial begin
    int k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset settings: neutral, bounds of both fields,
    // the equality edge of the waste test, then climbs onto both clamps.
    send_word('{wasted_bytes: 32'd0, bytes_read: 32'd0});
    send_word('{wasted_bytes: 32'd0, bytes_read: 32'hFFFF_FFFF});
    send_word('{wasted_bytes: 32'd0, bytes_read: 32'd1});
    send_word('{wasted_bytes: 32'd1, bytes_read: 32'd0});
    send_word('{wasted_bytes: 32'hFFFF_FFFF, bytes_read: 32'hFFFF_FFFF});
    send_word('{wasted_bytes: 32'hFFFF_FFFF, bytes_read: 32'd0});
    send_word('{wasted_bytes: 32'd1, bytes_read: 32'd1});
    send_word('{wasted_bytes: 32'd1, bytes_read: 32'd2});
    repeat (9) send_word('{wasted_bytes: 32'd0, bytes_read: 32'hFFFF_FFFF});
    repeat (9) send_word('{wasted_bytes: 32'hFFFF_FFFF, bytes_read: 32'd0});

    // No unit and the widest bounds: long runs drive the step into saturation.
    configure(31'd0, 31'h7FFF_FFFF, 31'd0, 31'd100, 31'h4000_0000);
    random_block(80, 32, 40);

    // Largest unit (upper bits masked away) starting at the upper bound.
    configure(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd100, 31'h7FFF_FFFF);
    random_block(60, 1, 30);

    // Crossed bounds are applied as they stand.
    configure(31'd1000000, 31'd1000, 31'd4096, 31'd100, 31'd5000);
    random_block(50, 1, 20);

    // Start below, then above, the bounds; the reload keeps the step.
    configure(31'd4096, 31'd65536, 31'd1000, 31'd100, 31'd0);
    random_block(40, 1, 20);
    drain();
    write_reg(REG_INITIAL_SIZE, 31'h7FFF_FFFF);
    random_block(40, 1, 20);

    // Smallest and largest waste factors.
    configure(31'd4096, 31'd1048576, 31'd4096, 31'd1, 31'd65536);
    random_block(50, 1, 20);
    configure(31'd4096, 31'd1048576, 31'd4096, 31'h7FFF_FFFF, 31'd65536);
    random_block(50, 1, 20);

    // Tiny sizes, a masked factor write, and writes to unused indexes.
    configure(31'd10, 31'd100, 31'd1, 31'h7ABC_0064, 31'd50);
    for (k = REG_INITIAL_SIZE + 1; k < 2 ** CFG_IDX_W; k++) begin
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    random_block(50, 1, 20);

    // Both bounds equal.
    configure(31'd8192, 31'd8192, 31'd4096, 31'd100, 31'd8192);
    random_block(30, 1, 10);

    // Reset settings again, with the result side held off so the block backs up.
    configure(RST_MIN_SIZE, RST_MAX_SIZE, 31'(RST_SIZE_UNIT), 31'(RST_WASTE_FACTOR),
              RST_INITIAL_SIZE);
    hold_off_req = 1'b1;
    random_block(60, 1, 20);

    // Final stretch at full rate on both sides.
    calm = 1'b1;
    random_block(160, 1, 20);

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("adaptive_read_cache_sizer regression: pass");
    end else begin
      $display("adaptive_read_cache_sizer regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/arcs_pkg.sv
hdl/arcs_update.sv
hdl/adaptive_read_cache_sizer.sv
hdl/arcs_checker.sv
dv/adaptive_read_cache_sizer_checker.sv
dv/adaptive_read_cache_sizer_tb.sv
